// ----- rtl/letterbox_nearest_scaler_assert.svh -----
// Assertion macros shared by the scaler RTL.
// Needs a clock and an active-low reset passed in by the user.
`ifndef LETTERBOX_NEAREST_SCALER_ASSERT_SVH
`define LETTERBOX_NEAREST_SCALER_ASSERT_SVH

// Property holds at every clock edge outside reset.
`define LBS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition never seen at a clock edge outside reset.
`define LBS_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/lbs_pkg.sv -----
// Shared constants and types of the letterbox scaler.
// No dependencies.
package lbs_pkg;
    localparam int PREVIEW_W      = 320;
    localparam int PREVIEW_H      = 180;
    localparam int MAX_SOURCE_DIM = 4096;
    localparam int MAX_RUN        = 8;

    localparam int DIM_W   = 13;   // source size, holds MAX_SOURCE_DIM itself
    localparam int POS_W   = 12;   // source coordinate
    localparam int FW_W    = 9;    // fitted width / column
    localparam int FH_W    = 8;    // fitted height / row
    localparam int DVD_W   = 21;   // dividend and quotient of the divider
    localparam int NBITS_W = 5;

    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;

    typedef struct packed {
        logic             fit;    // latch a new fit first
        logic             emit;   // pixel produces preview pixels
        logic [POS_W-1:0] sx;
        logic [POS_W-1:0] sy;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [7:0]       b2;
    } entry_t;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DIM_W-1:0]   divisor;
        logic [NBITS_W-1:0] nbits;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;
endpackage

// ----- rtl/letterbox_nearest_scaler.sv -----
// Letterbox nearest-neighbour scaler into a 320x180 preview.
// Source words enter on the input channel in raster order, frame_start on the
// first pixel of each frame. A preview pixel that samples a source pixel
// leaves as one word on the output channel (dest_x, dest_y, three bytes),
// rows then columns ascending, last_of_run set on the final word of a pixel;
// runs over MAX_RUN per axis are cut. Border fill and the constant fourth
// byte belong to the destination store. Config: cfg_index 0 = source_width,
// 1 = source_height, 13-bit data, values above 4096 saturate. cfg_ready is
// high only while the block is idle.
// Sequence: a frame_start pixel first fits the frame with one 21-bit
// division, or two when the height fit falls back to a width division;
// every emitting pixel is popped, runs four 9-bit divisions and a clamp step,
// then emits its words. The single shared restoring divider sets the rate;
// the next pixel is popped only once the output register is empty.
// A two-word queue lets the front take the next pixel while the back works.
// Reset: sizes return to 40 x 23, no frame active, the fit clears, the queue
// and output register empty. Pixels before the first frame_start are dropped.
// When the receiver stalls the output word holds and emission waits; the
// queue fills and in_ready drops.
// Depends on lbs_pkg, lbs_front, lbs_queue, lbs_back.
module letterbox_nearest_scaler
    import lbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             frame_start,
    input  logic [7:0]       byte0,
    input  logic [7:0]       byte1,
    input  logic [7:0]       byte2,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [8:0]       dest_x,
    output logic [7:0]       dest_y,
    output logic [7:0]       out_byte0,
    output logic [7:0]       out_byte1,
    output logic [7:0]       out_byte2,
    output logic             last_of_run,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [12:0]      cfg_data
);
    logic [DIM_W-1:0] src_w_reg, src_w_next;
    logic [DIM_W-1:0] src_h_reg, src_h_next;
    logic [DIM_W-1:0] cfg_sat;
    logic             push, pop, q_ne, q_nf, back_busy;
    entry_t           push_entry, head;

    // queue and back end empty means no word is still owed
    assign cfg_ready = !q_ne && !back_busy;
    assign in_ready  = q_nf;
    assign cfg_sat   = (cfg_data > DIM_W'(MAX_SOURCE_DIM)) ? DIM_W'(MAX_SOURCE_DIM) : cfg_data;

    always_comb
    begin
        src_w_next = src_w_reg;
        src_h_next = src_h_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  src_w_next = cfg_sat;
                REG_SOURCE_HEIGHT: src_h_next = cfg_sat;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= DIM_W'(40);
            src_h_reg <= DIM_W'(23);
        end
        else
        begin
            src_w_reg <= src_w_next;
            src_h_reg <= src_h_next;
        end
    end

    lbs_front u_front (
        .clk(clk), .rst_n(rst_n), .accept(in_valid && in_ready),
        .frame_start(frame_start), .byte0(byte0), .byte1(byte1), .byte2(byte2),
        .src_w(src_w_reg), .src_h(src_h_reg), .push(push), .entry(push_entry)
    );

    lbs_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_entry(push_entry),
        .pop(pop), .head(head), .not_empty(q_ne), .not_full(q_nf)
    );

    lbs_back u_back (
        .clk(clk), .rst_n(rst_n), .src_w(src_w_reg), .src_h(src_h_reg),
        .head(head), .head_valid(q_ne), .pop(pop), .busy(back_busy),
        .out_valid(out_valid), .out_ready(out_ready), .dest_x(dest_x),
        .dest_y(dest_y), .out_byte0(out_byte0), .out_byte1(out_byte1),
        .out_byte2(out_byte2), .last_of_run(last_of_run)
    );
endmodule

// ----- rtl/lbs_front.sv -----
// Front end: accepts source words, tracks raster position and frame state.
// Depends on lbs_pkg.
module lbs_front
    import lbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             frame_start,
    input  logic [7:0]       byte0,
    input  logic [7:0]       byte1,
    input  logic [7:0]       byte2,
    input  logic [DIM_W-1:0] src_w,
    input  logic [DIM_W-1:0] src_h,
    output logic             push,
    output entry_t           entry
);
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic             active_reg, active_next;

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        active_next = active_reg;
        push        = 1'b0;
        entry.fit   = frame_start;
        entry.emit  = 1'b0;
        entry.sx    = col_reg[POS_W-1:0];
        entry.sy    = row_reg[POS_W-1:0];
        entry.b0    = byte0;
        entry.b1    = byte1;
        entry.b2    = byte2;
        if (accept)
        begin
            if (frame_start)
            begin
                col_next    = '0;
                row_next    = '0;
                active_next = 1'b1;
            end
            if (active_next)
            begin
                if (src_w != '0 && src_h != '0 && col_next >= src_w)
                begin
                    col_next = '0;
                    row_next = row_next + 1'b1;
                end
                if (src_w == '0 || src_h == '0 || row_next >= src_h)
                begin
                    if (src_h != '0 && row_next >= src_h)
                        active_next = 1'b0;
                    push = frame_start;
                end
                else
                begin
                    push       = 1'b1;
                    entry.emit = 1'b1;
                    entry.sx   = col_next[POS_W-1:0];
                    entry.sy   = row_next[POS_W-1:0];
                    col_next   = col_next + 1'b1;
                    if (col_next >= src_w)
                    begin
                        col_next = '0;
                        row_next = row_next + 1'b1;
                        if (row_next >= src_h)
                            active_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            active_reg <= active_next;
        end
    end
endmodule

// ----- rtl/lbs_queue.sv -----
// Two-entry queue between front and back end.
// Depends on lbs_pkg.
module lbs_queue
    import lbs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   not_empty,
    output logic   not_full
);
    entry_t     mem_reg [2];
    logic [1:0] valid_reg, valid_next;
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;

    assign head      = mem_reg[rd_reg];
    assign not_empty = valid_reg[rd_reg];
    assign not_full  = !valid_reg[wr_reg];

    always_comb
    begin
        valid_next = valid_reg;
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        if (pop && not_empty)
        begin
            valid_next[rd_reg] = 1'b0;
            rd_next            = !rd_reg;
        end
        if (push && not_full)
        begin
            valid_next[wr_reg] = 1'b1;
            wr_next            = !wr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && not_full)
            mem_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
        end
    end
endmodule

// ----- rtl/lbs_div.sv -----
// Restoring divider, one quotient bit per cycle, quotient width chosen per request.
// Depends on lbs_pkg.
module lbs_div
    import lbs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [NBITS_W-1:0] cnt_reg, cnt_next;
    logic [DIM_W-1:0]   rem_reg, rem_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [DVD_W-1:0]   quo_reg, quo_next;
    logic [DIM_W:0]     trial;
    logic [DIM_W-1:0]   divisor_reg, divisor_next;

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        trial        = {rem_reg, dvd_reg[DVD_W-1]};
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = req.nbits;
            // bits above the quotient width start out in the remainder
            rem_next     = DIM_W'(req.dividend >> req.nbits);
            quo_next     = '0;
            divisor_next = req.divisor;
            dvd_next     = req.dividend << (NBITS_W'(DVD_W) - req.nbits);
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next = DIM_W'(trial - {1'b0, divisor_reg});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIM_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NBITS_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end
endmodule

// ----- rtl/lbs_back.sv -----
// Back end: frame fit, run edges through the divider, emission of preview words.
// Depends on lbs_pkg, lbs_div and the assertion macro header.
`include "letterbox_nearest_scaler_assert.svh"
module lbs_back
    import lbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIM_W-1:0] src_w,
    input  logic [DIM_W-1:0] src_h,
    input  entry_t           head,
    input  logic             head_valid,
    output logic             pop,
    output logic             busy,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [8:0]       dest_x,
    output logic [7:0]       dest_y,
    output logic [7:0]       out_byte0,
    output logic [7:0]       out_byte1,
    output logic [7:0]       out_byte2,
    output logic             last_of_run
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIT1  = 4'd1;
    localparam logic [3:0] S_FIT2L = 4'd2;
    localparam logic [3:0] S_FIT2  = 4'd3;
    localparam logic [3:0] S_FITB  = 4'd4;
    localparam logic [3:0] S_ELNCH = 4'd5;
    localparam logic [3:0] S_EWAIT = 4'd6;
    localparam logic [3:0] S_ECLMP = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    localparam logic [NBITS_W-1:0] FIT_BITS  = NBITS_W'(DVD_W);
    localparam logic [NBITS_W-1:0] EDGE_BITS = NBITS_W'(FW_W);

    logic [3:0]       state_reg, state_next;
    entry_t           ent_reg, ent_next;
    logic [FW_W-1:0]  fw_reg, fw_next;
    logic [FH_W-1:0]  fh_reg, fh_next;
    logic [7:0]       bx_reg, bx_next;
    logic [6:0]       by_reg, by_next;
    logic [1:0]       k_reg, k_next;
    logic [FW_W-1:0]  edge_reg [4];
    logic [FW_W-1:0]  edge_next [4];
    logic [FW_W-1:0]  x_reg, x_next;
    logic [FW_W-1:0]  y_reg, y_next;
    logic             ov_reg, ov_next;
    logic [8:0]       dx_reg, dx_next;
    logic [7:0]       dy_reg, dy_next;
    logic             last_reg, last_next;

    div_req_t         dreq;
    div_rsp_t         drsp;
    logic [DIM_W-1:0] wp, hp;
    logic [DIM_W-1:0] e_s, e_src;
    logic [FW_W-1:0]  e_fit;
    logic [FW_W-1:0]  q_clamped;
    logic             row_end, col_end;

    lbs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign wp = (src_w == '0) ? DIM_W'(1) : src_w;
    assign hp = (src_h == '0) ? DIM_W'(1) : src_h;

    // operands of the current run edge: rows first, then columns
    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                e_s = {1'b0, ent_reg.sy}; e_fit = {1'b0, fh_reg}; e_src = src_h;
            end
            2'd1:
            begin
                e_s = {1'b0, ent_reg.sy} + 1'b1; e_fit = {1'b0, fh_reg}; e_src = src_h;
            end
            2'd2:
            begin
                e_s = {1'b0, ent_reg.sx}; e_fit = fw_reg; e_src = src_w;
            end
            default:
            begin
                e_s = {1'b0, ent_reg.sx} + 1'b1; e_fit = fw_reg; e_src = src_w;
            end
        endcase
    end

    assign q_clamped = (drsp.quotient > DVD_W'(e_fit)) ? e_fit : drsp.quotient[FW_W-1:0];
    assign col_end   = (x_reg + 1'b1 == edge_reg[3]);
    assign row_end   = (y_reg + 1'b1 == edge_reg[1]);

    // the bytes come from ent_reg, so the next pixel waits for the output word to leave
    assign pop         = (state_reg == S_IDLE) && head_valid && !ov_reg;
    assign busy        = (state_reg != S_IDLE) || ov_reg;
    assign out_valid   = ov_reg;
    assign dest_x      = dx_reg;
    assign dest_y      = dy_reg;
    assign out_byte0   = ent_reg.b0;
    assign out_byte1   = ent_reg.b1;
    assign out_byte2   = ent_reg.b2;
    assign last_of_run = last_reg;

    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        fw_next    = fw_reg;
        fh_next    = fh_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        k_next     = k_reg;
        edge_next  = edge_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        ov_next    = ov_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        last_next  = last_reg;
        dreq.start    = 1'b0;
        dreq.dividend = DVD_W'(hp) * DVD_W'(PREVIEW_W);
        dreq.divisor  = wp;
        dreq.nbits    = FIT_BITS;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    ent_next = head;
                    k_next   = 2'd0;
                    if (head.fit)
                    begin
                        dreq.start = 1'b1;
                        state_next = S_FIT1;
                    end
                    else if (head.emit)
                        state_next = S_ELNCH;
                end
            end
            S_FIT1:
            begin
                if (drsp.done)
                begin
                    fw_next = FW_W'(PREVIEW_W);
                    if (drsp.quotient > DVD_W'(PREVIEW_H))
                    begin
                        fh_next    = FH_W'(PREVIEW_H);
                        state_next = S_FIT2L;
                    end
                    else
                    begin
                        fh_next    = (drsp.quotient == '0) ? FH_W'(1)
                                                           : drsp.quotient[FH_W-1:0];
                        state_next = S_FITB;
                    end
                end
            end
            S_FIT2L:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = DVD_W'(wp) * DVD_W'(PREVIEW_H);
                dreq.divisor  = hp;
                state_next    = S_FIT2;
            end
            S_FIT2:
            begin
                if (drsp.done)
                begin
                    if (drsp.quotient == '0)
                        fw_next = FW_W'(1);
                    else if (drsp.quotient > DVD_W'(PREVIEW_W))
                        fw_next = FW_W'(PREVIEW_W);
                    else
                        fw_next = drsp.quotient[FW_W-1:0];
                    state_next = S_FITB;
                end
            end
            S_FITB:
            begin
                bx_next    = 8'((FW_W'(PREVIEW_W) - fw_reg) >> 1);
                by_next    = 7'((FH_W'(PREVIEW_H) - fh_reg) >> 1);
                state_next = ent_reg.emit ? S_ELNCH : S_IDLE;
            end
            S_ELNCH:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = DVD_W'(e_s) * DVD_W'(e_fit) + DVD_W'(e_src) - 1'b1;
                dreq.divisor  = e_src;
                dreq.nbits    = EDGE_BITS;
                state_next    = S_EWAIT;
            end
            S_EWAIT:
            begin
                if (drsp.done)
                begin
                    edge_next[k_reg] = q_clamped;
                    k_next           = k_reg + 1'b1;
                    state_next       = (k_reg == 2'd3) ? S_ECLMP : S_ELNCH;
                end
            end
            S_ECLMP:
            begin
                // long upscale runs are cut to MAX_RUN per axis
                if (edge_reg[1] > edge_reg[0] + FW_W'(MAX_RUN))
                    edge_next[1] = edge_reg[0] + FW_W'(MAX_RUN);
                if (edge_reg[3] > edge_reg[2] + FW_W'(MAX_RUN))
                    edge_next[3] = edge_reg[2] + FW_W'(MAX_RUN);
                y_next = edge_reg[0];
                x_next = edge_reg[2];
                if (edge_reg[0] >= edge_reg[1] || edge_reg[2] >= edge_reg[3])
                    state_next = S_IDLE;
                else
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next   = 1'b1;
                    dx_next   = 9'({1'b0, bx_reg} + x_reg);
                    dy_next   = 8'({2'b0, by_reg} + y_reg);
                    last_next = row_end && col_end;
                    if (col_end)
                    begin
                        x_next = edge_reg[2];
                        y_next = y_reg + 1'b1;
                        if (row_end)
                            state_next = S_IDLE;
                    end
                    else
                        x_next = x_reg + 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        edge_reg <= edge_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        last_reg <= last_next;
        k_reg    <= k_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            fw_reg    <= '0;
            fh_reg    <= '0;
            bx_reg    <= '0;
            by_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            fw_reg    <= fw_next;
            fh_reg    <= fh_next;
            bx_reg    <= bx_next;
            by_reg    <= by_next;
        end
    end

    `LBS_ASSERT(a_emit_in_run, clk, rst_n, (state_reg == S_EMIT) |-> (y_reg < edge_reg[1] && x_reg < edge_reg[3]), "emit position outside run")
    `LBS_ASSERT(a_emit_fitted, clk, rst_n, (state_reg == S_EMIT) |-> (fw_reg != '0 && fh_reg != '0), "emit before frame fit")
    `LBS_NEVER(a_div_stray, clk, rst_n, drsp.done && state_reg != S_FIT1 && state_reg != S_FIT2 && state_reg != S_EWAIT, "divider result with nobody waiting")
    `LBS_ASSERT(a_pop_idle, clk, rst_n, pop |=> (state_reg != S_EMIT), "emission started without edges")
endmodule
